FILE: design/peak_env_pkg.sv
// ----------------------------------------------------------------------------
// Peak envelope trigger package
// Widths, reset values, event codes and register indexes shared by the
// peak envelope sound trigger.
// ----------------------------------------------------------------------------
package peak_env_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int HISTORY      = 1024;
    localparam int HIST_BITS    = $clog2(HISTORY);
    localparam int SUM_BITS     = SAMPLE_BITS + HIST_BITS;
    localparam int BYTE_SHIFT   = SAMPLE_BITS - 8;
    localparam int THR_BITS     = 10;
    localparam int CAPLEN_BITS  = 16;
    localparam int CMP_BITS     = SAMPLE_BITS + 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [THR_BITS-1:0]    THRESHOLD_RESET   = THR_BITS'(120);
    localparam logic [CAPLEN_BITS-1:0] CAPTURE_LEN_RESET = CAPLEN_BITS'(32768);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PEAK    = 2'd1,
        EV_TRIGGER = 2'd2,
        EV_CAPTURE = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD   = 1'b0,
        REG_CAPTURE_LEN = 1'b1
    } cfg_index_t;

endpackage

FILE: design/peak_envelope_sound_trigger.sv
// ----------------------------------------------------------------------------
// Peak envelope sound trigger
// Finds local maxima in a stream of converter samples, keeps a running sum
// of the last HISTORY peaks and fires a capture when a peak rises above the
// running average by the programmed threshold.
//
// Usage: one sample enters per s_ transaction, one result leaves per m_
// transaction. Each accepted sample yields exactly one result in the next
// cycle, held in an output register. A new sample is taken in every cycle
// while the output register is empty or being drained, so throughput is one
// sample per cycle; the combinational path is the peak compare against the
// running average and the sum update. The peak ring is a 1024-entry memory
// whose entry at the next write slot is read ahead into a register, so the value
// that a new peak displaces is already registered when the peak arrives.
// When the receiver stalls, the result holds and s_ready drops until it is
// taken. Reset clears the sample history, sum, ring pointer and capture
// count and loads the register defaults; the ring contents are not cleared
// and are only read once every entry has been written.
// ----------------------------------------------------------------------------
module peak_envelope_sound_trigger (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [peak_env_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [peak_env_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [peak_env_pkg::SAMPLE_BITS-1:0]   s_adc_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output peak_env_pkg::event_kind_t              m_event_kind,
    output logic [7:0]                             m_capture_byte,
    output logic                                   m_capture_last,
    output logic [peak_env_pkg::SAMPLE_BITS-1:0]   m_peak_value,
    output logic [peak_env_pkg::SAMPLE_BITS-1:0]   m_peak_average
);
    import peak_env_pkg::*;

    logic [THR_BITS-1:0]    threshold_reg;
    logic [CAPLEN_BITS-1:0] capture_len_reg;

    logic                   seeded_reg, seeded_next;
    sample_t                older_reg, older_next;
    sample_t                middle_reg, middle_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [HIST_BITS-1:0]   slot_reg, slot_next;
    logic                   full_reg, full_next;
    logic [CAPLEN_BITS-1:0] capture_left_reg, capture_left_next;

    sample_t                peak_ring_mem [HISTORY];
    sample_t                ring_rd_reg;

    logic                   m_valid_reg, m_valid_next;
    event_kind_t            kind_reg, kind_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    sample_t                peak_reg, peak_next;
    sample_t                avg_reg, avg_next;

    logic                   accept;
    logic                   store;
    sample_t                avg_cur;
    logic [CMP_BITS-1:0]    trig_level;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign avg_cur = sum_reg[SUM_BITS-1:HIST_BITS];
    assign trig_level = CMP_BITS'(avg_cur) + CMP_BITS'(threshold_reg);

    always_comb begin
        seeded_next       = seeded_reg;
        older_next        = older_reg;
        middle_next       = middle_reg;
        sum_next          = sum_reg;
        slot_next         = slot_reg;
        full_next         = full_reg;
        capture_left_next = capture_left_reg;
        kind_next         = EV_NONE;
        byte_next         = '0;
        last_next         = 1'b0;
        peak_next         = '0;
        store             = 1'b0;

        if (accept) begin
            if (capture_left_reg != '0) begin
                kind_next         = EV_CAPTURE;
                byte_next         = s_adc_sample[SAMPLE_BITS-1:BYTE_SHIFT];
                last_next         = (capture_left_reg == CAPLEN_BITS'(1));
                capture_left_next = capture_left_reg - CAPLEN_BITS'(1);
            end else if (!seeded_reg) begin
                seeded_next = 1'b1;
                older_next  = s_adc_sample;
                middle_next = s_adc_sample;
            end else begin
                if (middle_reg > s_adc_sample && middle_reg > older_reg) begin
                    store     = 1'b1;
                    peak_next = middle_reg;
                    if (full_reg && CMP_BITS'(middle_reg) > trig_level) begin
                        kind_next         = EV_TRIGGER;
                        capture_left_next = capture_len_reg;
                    end else begin
                        kind_next = EV_PEAK;
                    end
                end
                older_next  = middle_reg;
                middle_next = s_adc_sample;
            end
        end

        if (store) begin
            sum_next = sum_reg - (full_reg ? SUM_BITS'(ring_rd_reg) : '0)
                     + SUM_BITS'(middle_reg);
            if (slot_reg == HIST_BITS'(HISTORY - 1)) begin
                slot_next = '0;
                full_next = 1'b1;
            end else begin
                slot_next = slot_reg + HIST_BITS'(1);
            end
        end

        avg_next = sum_next[SUM_BITS-1:HIST_BITS];

        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            capture_len_reg  <= CAPTURE_LEN_RESET;
            seeded_reg       <= 1'b0;
            older_reg        <= '0;
            middle_reg       <= '0;
            sum_reg          <= '0;
            slot_reg         <= '0;
            full_reg         <= 1'b0;
            capture_left_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    REG_THRESHOLD:   threshold_reg   <= cfg_data[THR_BITS-1:0];
                    REG_CAPTURE_LEN: capture_len_reg <= cfg_data[CAPLEN_BITS-1:0];
                    default: ;
                endcase
            end
            seeded_reg       <= seeded_next;
            older_reg        <= older_next;
            middle_reg       <= middle_next;
            sum_reg          <= sum_next;
            slot_reg         <= slot_next;
            full_reg         <= full_next;
            capture_left_reg <= capture_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
            peak_reg <= peak_next;
            avg_reg  <= avg_next;
        end
    end

    // The entry at the next write slot is prefetched so a displaced peak is
    // ready for the sum update on the following transaction.
    always_ff @(posedge aclk) begin
        if (store) begin
            peak_ring_mem[slot_reg] <= middle_reg;
        end
        ring_rd_reg <= peak_ring_mem[slot_next];
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_capture_byte = byte_reg;
    assign m_capture_last = last_reg;
    assign m_peak_value   = peak_reg;
    assign m_peak_average = avg_reg;

    a_capture_fields_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg != EV_CAPTURE) |-> (byte_reg == '0 && !last_reg))
        else $error("capture fields set outside a capture byte");

    a_peak_only_on_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (kind_reg == EV_NONE || kind_reg == EV_CAPTURE))
        |-> (peak_reg == '0))
        else $error("peak value reported without a peak");

    a_capture_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (capture_left_reg != '0) |-> (seeded_reg && full_reg))
        else $error("capture running before the ring is full");

    a_full_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("ring full flag cleared");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(kind_reg)
        && $stable(avg_reg)))
        else $error("result changed while the receiver stalled");

endmodule

FILE: test/tb_peak_envelope_sound_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak envelope sound trigger testbench
// Streams converter samples through the trigger. A built-in predictor
// computes the expected result of every sample, and the results are
// compared field by field. The run seeds the detector and checks corner
// samples first. It then fills the peak history, fires a capture with the
// reset register values, and sweeps the threshold and capture length. A
// register write is made in the middle of a maximum length capture, and the
// run ends with a stream that has no idle cycles on either side.
// ----------------------------------------------------------------------------
module tb_peak_envelope_sound_trigger;

    import peak_env_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0] cap_byte;
        logic       cap_last;
        sample_t    peak;
        sample_t    avg;
    } env_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    sample_t                   s_adc_sample;
    logic                      m_valid;
    logic                      m_ready;
    event_kind_t               m_event_kind;
    logic [7:0]                m_capture_byte;
    logic                      m_capture_last;
    sample_t                   m_peak_value;
    sample_t                   m_peak_average;

    logic [THR_BITS-1:0]       thr_level = THRESHOLD_RESET;
    logic [CAPLEN_BITS-1:0]    cap_len = CAPTURE_LEN_RESET;
    logic                      seeded = 1'b0;
    sample_t                   older_smp = '0;
    sample_t                   middle_smp = '0;
    sample_t                   peak_ring [HISTORY];
    logic [SUM_BITS-1:0]       peak_sum = '0;
    logic [HIST_BITS-1:0]      ring_slot = '0;
    logic                      ring_full = 1'b0;
    logic [CAPLEN_BITS-1:0]    capture_left = '0;

    env_result_t               pending_results[$];
    int                        samples_sent = 0;
    int                        results_seen = 0;
    int                        triggers_predicted = 0;
    int                        error_count = 0;
    int                        quiet_cycles = 0;
    int                        stall_left = 0;
    logic                      calm = 1'b0;
    logic                      idling_on = 1'b1;

    peak_envelope_sound_trigger dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_adc_sample   (s_adc_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_capture_byte (m_capture_byte),
        .m_capture_last (m_capture_last),
        .m_peak_value   (m_peak_value),
        .m_peak_average (m_peak_average)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic env_result_t predict_envelope(sample_t s);
        env_result_t r;
        sample_t     mid;
        r = '0;
        if (capture_left != 0) begin
            r.kind = EV_CAPTURE;
            r.cap_byte = 8'(s >> BYTE_SHIFT);
            r.cap_last = (capture_left == 1);
            capture_left--;
        end else if (!seeded) begin
            seeded = 1'b1;
            older_smp = s;
            middle_smp = s;
        end else begin
            mid = middle_smp;
            if (mid > s && mid > older_smp) begin
                r.peak = mid;
                if (ring_full && int'(mid) > int'(peak_sum / HISTORY) + int'(thr_level)) begin
                    r.kind = EV_TRIGGER;
                    capture_left = cap_len;
                    triggers_predicted++;
                end else begin
                    r.kind = EV_PEAK;
                end
                if (ring_full) begin
                    peak_sum = peak_sum - peak_ring[ring_slot];
                end
                peak_ring[ring_slot] = mid;
                peak_sum = peak_sum + mid;
                if (ring_slot == HISTORY - 1) begin
                    ring_slot = '0;
                    ring_full = 1'b1;
                end else begin
                    ring_slot++;
                end
            end
            older_smp = mid;
            middle_smp = s;
        end
        r.avg = sample_t'(peak_sum / HISTORY);
        return r;
    endfunction

    function automatic sample_t shaped_sample();
        int pick;
        pick = $urandom_range(0, 23);
        if (pick < 3) return sample_t'($urandom_range(0, 1023));
        if (pick < 7) return sample_t'($urandom_range(850, 1023));
        return sample_t'($urandom_range(150, 600));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want_v);
        $display("MISMATCH %s: got %0h expected %0h (result %0d, t=%0t)",
                 what, got, want_v, results_seen, $time);
        error_count++;
    endtask

    task automatic send_sample(input sample_t v);
        s_valid <= 1'b1;
        s_adc_sample <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_envelope(v));
        samples_sent++;
        if (idling_on && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] thr_word,
                                input logic [CFG_DATA_BITS-1:0] len_word);
        cfg_we <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= thr_word;
        @(posedge aclk);
        cfg_index <= REG_CAPTURE_LEN;
        cfg_data <= len_word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        thr_level = thr_word[THR_BITS-1:0];
        cap_len = len_word[CAPLEN_BITS-1:0];
    endtask

    task automatic fire_trigger();
        int start_count;
        start_count = triggers_predicted;
        for (int n = 0; n < 30 && triggers_predicted == start_count; n++) begin
            send_sample(10'd100);
            send_sample(10'd1023);
            send_sample(10'd100);
        end
    endtask

    // The first sample seeds both neighbors; plateaus must not count as peaks.
    task automatic test_first_samples();
        sample_t corner_samples [21] = '{
            10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd0,
            10'd512, 10'd513, 10'd512, 10'd0, 10'd1, 10'd0, 10'd0, 10'd0,
            10'd1022, 10'd1023, 10'd1022, 10'd1, 10'd1023, 10'd0
        };
        foreach (corner_samples[i]) begin
            send_sample(corner_samples[i]);
        end
    endtask

    task automatic test_fill_history();
        while (!ring_full) begin
            send_sample(sample_t'($urandom_range(300, 700)));
            send_sample(sample_t'($urandom_range(0, 299)));
        end
    endtask

    task automatic test_default_capture();
        fire_trigger();
        while (capture_left != 0) send_sample(sample_t'($urandom));
    endtask

    task automatic test_capture_settings();
        int                     phase_no;
        int                     start_sent;
        int                     start_trig;
        logic [THR_BITS-1:0]    thr;
        logic [CAPLEN_BITS-1:0] len;
        phase_no = 0;
        start_sent = samples_sent;
        start_trig = triggers_predicted;
        while (phase_no < 6 || ((samples_sent - start_sent < 450 ||
               triggers_predicted - start_trig < 48) && phase_no < 60)) begin
            unique case (phase_no)
                0: begin
                    thr = '0;
                    len = '0;
                end
                1: begin
                    thr = '1;
                    len = 16'd1;
                end
                2: begin
                    thr = '0;
                    len = 16'd1;
                end
                default: begin
                    thr = THR_BITS'($urandom_range(0, 300));
                    len = CAPLEN_BITS'($urandom_range(0, 12));
                end
            endcase
            drain_results();
            program_regs({6'($urandom), thr}, len);
            repeat (70) send_sample(shaped_sample());
            phase_no++;
        end
    endtask

    // A capture in progress keeps its count when the registers are rewritten.
    task automatic test_write_during_capture();
        drain_results();
        program_regs(16'hFC64, 16'hFFFF);
        fire_trigger();
        repeat (500) send_sample(sample_t'($urandom));
        drain_results();
        program_regs(16'hFFFF, 16'd2);
        while (capture_left != 0) send_sample(sample_t'($urandom));
        repeat (60) send_sample(shaped_sample());
    endtask

    task automatic test_steady_stream();
        drain_results();
        idling_on = 1'b0;
        program_regs(16'd60, 16'd4);
        repeat (150) send_sample(shaped_sample());
    endtask

    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) begin
            calm <= ~calm;
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling_on && !calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        env_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result without a pending sample", 32'(m_event_kind), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_event_kind !== want.kind)
                    report_mismatch("event_kind", 32'(m_event_kind), 32'(want.kind));
                if (m_capture_byte !== want.cap_byte)
                    report_mismatch("capture_byte", 32'(m_capture_byte), 32'(want.cap_byte));
                if (m_capture_last !== want.cap_last)
                    report_mismatch("capture_last", 32'(m_capture_last), 32'(want.cap_last));
                if (m_peak_value !== want.peak)
                    report_mismatch("peak_value", 32'(m_peak_value), 32'(want.peak));
                if (m_peak_average !== want.avg)
                    report_mismatch("peak_average", 32'(m_peak_average), 32'(want.avg));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_adc_sample <= '0;
        m_ready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_first_samples();
        test_fill_history();
        test_default_capture();
        test_capture_settings();
        test_write_during_capture();
        test_steady_stream();
        drain_results();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
